### hdl/cstfp_pkg.sv
// Shared types, constants and functions for the callsign text frame packer.
// No dependencies; used by cstfp_char_unit and callsign_text_frame_packer.
package cstfp_pkg;

  localparam int CHAR_W        = 8;
  localparam int CODE_BITS     = 6;
  localparam int CODE_SLOTS    = 8;
  localparam int CRC_W         = 8;
  localparam int SLOT_W        = $clog2(CODE_SLOTS);
  localparam int CNT_W         = $clog2(CODE_SLOTS + 1);
  localparam int PACK_W        = CODE_BITS * CODE_SLOTS;
  localparam int INFO_W        = PACK_W + CRC_W;
  localparam int OUT_W         = INFO_W + CNT_W + CRC_W;
  localparam int OUT_TDATA_W   = ((OUT_W + 7) / 8) * 8;
  localparam int MAX_CHARS_DEF = 8;

  localparam logic [CRC_W-1:0] CRC_POLY = 8'h1D;

  // punctuation band: ascii 38..47
  localparam logic [CHAR_W-1:0] PUNCT_LO = 8'd38;
  localparam logic [CHAR_W-1:0] PUNCT_HI = 8'd47;
  localparam logic [CHAR_W-1:0] PUNCT_OFS = 8'd37;
  localparam logic [CHAR_W-1:0] DIGIT_LO = 8'h30;
  localparam logic [CHAR_W-1:0] DIGIT_HI = 8'h39;
  localparam logic [CHAR_W-1:0] UPPER_LO = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_HI = 8'h5A;
  localparam logic [CHAR_W-1:0] LOWER_LO = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_HI = 8'h7A;
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd10;
  localparam logic [CHAR_W-1:0] ALPHA_BASE = 8'd20;

  // per-character result handed from the character unit to the top level
  typedef struct packed {
    logic                 is_zero;
    logic                 is_code;
    logic [CODE_BITS-1:0] code;
    logic [CRC_W-1:0]     crc_next;
  } char_res_t;

  // map one byte to its six-bit code, zero when the byte is skipped
  function automatic logic [CODE_BITS-1:0] map_char(input logic [CHAR_W-1:0] b);
    logic [CHAR_W-1:0] v;
    v = '0;
    if (b >= PUNCT_LO && b <= PUNCT_HI) begin
      v = b - PUNCT_OFS;
    end else if (b >= DIGIT_LO && b <= DIGIT_HI) begin
      v = b - DIGIT_LO + DIGIT_BASE;
    end else if (b >= UPPER_LO && b <= UPPER_HI) begin
      v = b - UPPER_LO + ALPHA_BASE;
    end else if (b >= LOWER_LO && b <= LOWER_HI) begin
      v = b - LOWER_LO + ALPHA_BASE;
    end
    return v[CODE_BITS-1:0];
  endfunction

  // crc-8 msb first over one code, unrolled eight shifts
  function automatic logic [CRC_W-1:0] crc8_step(input logic [CRC_W-1:0] crc,
                                                 input logic [CODE_BITS-1:0] code);
    logic [CRC_W-1:0] c;
    c = crc ^ CRC_W'(code);
    for (int i = 0; i < CRC_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hdl/cstfp_char_unit.sv
// Character unit: classifies one byte, maps it to a code and advances the crc.
// Depends on cstfp_pkg.
module cstfp_char_unit (
  input  logic [cstfp_pkg::CHAR_W-1:0] char_byte,
  input  logic [cstfp_pkg::CRC_W-1:0]  crc_in,
  output cstfp_pkg::char_res_t         res
);
  import cstfp_pkg::*;

  logic [CODE_BITS-1:0] code;

  // code lookup and crc update over that code
  always_comb begin
    code         = map_char(char_byte);
    res.is_zero  = (char_byte == '0);
    res.is_code  = (code != '0);
    res.code     = code;
    res.crc_next = crc8_step(crc_in, code);
  end

endmodule

### hdl/callsign_text_frame_packer.sv
// Top level of the callsign text frame packer; takes one character byte per word.
// Depends on cstfp_pkg and cstfp_char_unit.
//
// Takes one character word per clock while the input side is not stalled. A word
// passes an input register, then the character unit (code lookup and an unrolled
// crc-8 step) and the state update; the word with tlast loads the frame result into
// the result register as it leaves the input register. Throughput is one word per
// clock; the input side stalls only when a result waits in the output register,
// m_axis_tready is low and the next word in the input register is again a last
// word. Only the first MAX_CHARS bytes of a frame are examined, a zero byte ends
// examination, and the state clears itself after each result.
module callsign_text_frame_packer #(
  parameter int MAX_CHARS = cstfp_pkg::MAX_CHARS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cstfp_pkg::CHAR_W-1:0]        s_axis_tdata,  // [7:0] char_byte
  input  logic                                s_axis_tlast,  // last_char
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [55:0] info_word, [59:56] code_count, [67:60] crc_value, [71:68] zero
  output logic [cstfp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import cstfp_pkg::*;

  localparam int EXAM_W = $clog2(MAX_CHARS + 1);

  // input register
  logic              in_valid;
  logic [CHAR_W-1:0] in_byte;
  logic              in_last;

  // frame state
  logic [PACK_W-1:0] packed_codes;
  logic [CRC_W-1:0]  running_crc;
  logic [CNT_W-1:0]  codes_stored;
  logic [EXAM_W-1:0] bytes_examined;
  logic              ended_by_zero;

  logic [PACK_W-1:0] packed_codes_next;
  logic [CRC_W-1:0]  running_crc_next;
  logic [CNT_W-1:0]  codes_stored_next;
  logic [EXAM_W-1:0] bytes_examined_next;
  logic              ended_by_zero_next;

  logic      out_valid;
  logic      proc_go;
  logic      take;
  logic      store;
  char_res_t res;

  cstfp_char_unit u_char (
    .char_byte (in_byte),
    .crc_in    (running_crc),
    .res       (res)
  );

  // handshake: a last word needs room in the result register
  assign proc_go       = in_valid && (!in_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc_go;
  assign m_axis_tvalid = out_valid;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // next frame state for the word in the input register
  always_comb begin
    take  = !ended_by_zero && (bytes_examined < EXAM_W'(MAX_CHARS));
    store = take && !res.is_zero && res.is_code && (codes_stored < CNT_W'(CODE_SLOTS));

    packed_codes_next   = packed_codes;
    running_crc_next    = running_crc;
    codes_stored_next   = codes_stored;
    bytes_examined_next = bytes_examined;
    ended_by_zero_next  = ended_by_zero;

    if (take) begin
      bytes_examined_next = bytes_examined + EXAM_W'(1);
      if (res.is_zero) begin
        ended_by_zero_next = 1'b1;
      end
    end
    if (store) begin
      for (int k = 0; k < CODE_SLOTS; k++) begin
        if (codes_stored[SLOT_W-1:0] == SLOT_W'(k)) begin
          packed_codes_next[k*CODE_BITS +: CODE_BITS] = res.code;
        end
      end
      running_crc_next  = res.crc_next;
      codes_stored_next = codes_stored + CNT_W'(1);
    end
  end

  // frame state, cleared after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      packed_codes   <= '0;
      running_crc    <= '0;
      codes_stored   <= '0;
      bytes_examined <= '0;
      ended_by_zero  <= 1'b0;
    end else if (proc_go) begin
      if (in_last) begin
        packed_codes   <= '0;
        running_crc    <= '0;
        codes_stored   <= '0;
        bytes_examined <= '0;
        ended_by_zero  <= 1'b0;
      end else begin
        packed_codes   <= packed_codes_next;
        running_crc    <= running_crc_next;
        codes_stored   <= codes_stored_next;
        bytes_examined <= bytes_examined_next;
        ended_by_zero  <= ended_by_zero_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_go && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (proc_go && in_last) begin
      m_axis_tdata <= {(OUT_TDATA_W - OUT_W)'(0), running_crc_next, codes_stored_next,
                       packed_codes_next, running_crc_next};
    end
  end

  // checks on the frame state and result
  a_codes_bound: assert property (@(posedge clk) disable iff (rst)
    codes_stored <= CNT_W'(CODE_SLOTS))
    else $error("code count past slot limit");

  a_exam_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_examined <= EXAM_W'(MAX_CHARS))
    else $error("examined bytes past limit");

  a_empty_state: assert property (@(posedge clk) disable iff (rst)
    codes_stored == '0 |-> (running_crc == '0 && packed_codes == '0))
    else $error("crc or codes set with no codes stored");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (proc_go && in_last) |=> (codes_stored == '0 && bytes_examined == '0 && !ended_by_zero))
    else $error("state not cleared after frame");

  a_crc_copy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (m_axis_tdata[CRC_W-1:0] == m_axis_tdata[INFO_W+CNT_W +: CRC_W]))
    else $error("crc field differs from info word");

endmodule

### tb/tb_top.sv
// Self-checking testbench for callsign_text_frame_packer: drives character words,
// predicts each frame's packed word, code count and crc-8, and checks the results.
// Depends on cstfp_pkg and the packer RTL.
`timescale 1ns / 100ps

module tb_top;

  import cstfp_pkg::*;

  localparam int MSG_LIMIT    = MAX_CHARS_DEF;
  localparam int WORD_COUNT   = 1750;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [CRC_W-1:0] CRC8_POLY = 8'h1D;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              last_char;
  } char_word_t;

  typedef struct packed {
    logic [INFO_W-1:0] info_word;
    logic [CNT_W-1:0]  code_count;
    logic [CRC_W-1:0]  crc_value;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [CHAR_W-1:0] s_axis_tdata = '0;  // [7:0] char_byte
  logic s_axis_tlast = 1'b0;             // last_char
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // [55:0] info_word, [59:56] code_count, [67:60] crc_value, [71:68] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  char_word_t  char_words[$];
  frame_word_t frame_words[$];
  char_word_t  next_word;
  frame_word_t got, want;
  logic word_taken = 1'b0;
  int   words_sent = 0;
  int   errors = 0;
  logic calm;

  // packer state as seen from outside
  logic [PACK_W-1:0] pk_codes = '0;
  logic [CRC_W-1:0]  crc_acc = '0;
  logic [CNT_W-1:0]  n_codes = '0;
  logic [CNT_W-1:0]  n_seen = '0;
  logic              zero_seen = 1'b0;

  callsign_text_frame_packer #(.MAX_CHARS(MSG_LIMIT)) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stretch of the run with no idling on either side
  assign calm = (words_sent >= 700) && (words_sent < 1000);

  // six-bit code of a character, zero when skipped
  function automatic logic [CODE_BITS-1:0] char_code(input logic [CHAR_W-1:0] b);
    if (b >= 8'd38 && b <= 8'd47) return CODE_BITS'(b - 8'd37);
    if (b >= "0" && b <= "9") return CODE_BITS'(b - "0" + 8'd10);
    if (b >= "A" && b <= "Z") return CODE_BITS'(b - "A" + 8'd20);
    if (b >= "a" && b <= "z") return CODE_BITS'(b - "a" + 8'd20);
    return '0;
  endfunction

  // crc-8 msb first, one code per update
  function automatic logic [CRC_W-1:0] crc8_code(input logic [CRC_W-1:0] acc,
                                                 input logic [CODE_BITS-1:0] code);
    logic [CRC_W-1:0] r;
    r = acc ^ CRC_W'(code);
    repeat (8) r = r[CRC_W-1] ? ({r[CRC_W-2:0], 1'b0} ^ CRC8_POLY) : {r[CRC_W-2:0], 1'b0};
    return r;
  endfunction

  // fold one accepted character into the frame, queue the frame word on tlast
  task automatic pack_char(input logic [CHAR_W-1:0] b, input logic last);
    logic [CODE_BITS-1:0] code;
    frame_word_t fw;
    if (!zero_seen && n_seen < MSG_LIMIT) begin
      n_seen = n_seen + 1'b1;
      if (b == '0) begin
        zero_seen = 1'b1;
      end else begin
        code = char_code(b);
        if (code != '0 && n_codes < CODE_SLOTS) begin
          pk_codes[CODE_BITS*n_codes +: CODE_BITS] = code;
          crc_acc = crc8_code(crc_acc, code);
          n_codes = n_codes + 1'b1;
        end
      end
    end
    if (last) begin
      fw.info_word = {pk_codes, crc_acc};
      fw.code_count = n_codes;
      fw.crc_value = crc_acc;
      frame_words.push_back(fw);
      pk_codes = '0;
      crc_acc = '0;
      n_codes = '0;
      n_seen = '0;
      zero_seen = 1'b0;
    end
  endtask

  task automatic add_word(input logic [CHAR_W-1:0] b, input logic last);
    char_word_t w;
    w.char_byte = b;
    w.last_char = last;
    char_words.push_back(w);
  endtask

  // character word driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || word_taken) begin
      if (char_words.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
        next_word = char_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= next_word.char_byte;
        s_axis_tlast <= next_word.last_char;
        words_sent <= words_sent + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    m_axis_tready <= !rst && (calm || $urandom_range(99) >= 6);
  end

  // predict on accepted words, check accepted results
  always @(posedge clk) begin
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        pack_char(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.info_word = m_axis_tdata[INFO_W-1:0];
        got.code_count = m_axis_tdata[INFO_W +: CNT_W];
        got.crc_value = m_axis_tdata[INFO_W+CNT_W +: CRC_W];
        if (frame_words.size() == 0) begin
          $display("%0t: unexpected frame word %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = frame_words.pop_front();
          if (got.info_word !== want.info_word) begin
            $display("%0t: info_word expected %h actual %h", $time,
                     want.info_word, got.info_word);
            errors++;
          end
          if (got.code_count !== want.code_count) begin
            $display("%0t: code_count expected %0d actual %0d", $time,
                     want.code_count, got.code_count);
            errors++;
          end
          if (got.crc_value !== want.crc_value) begin
            $display("%0t: crc_value expected %h actual %h", $time,
                     want.crc_value, got.crc_value);
            errors++;
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    string dir_msg;
    int msg_len;
    int pick;
    logic [CHAR_W-1:0] b;
    // empty messages: zero byte on the last word, a skipped byte alone
    add_word(8'h00, 1'b1);
    add_word("!", 1'b1);
    // band edges of every class, then a last word past the limit
    dir_msg = "&/09AZaz";
    for (int i = 0; i < dir_msg.len(); i++) add_word(dir_msg[i], 1'b0);
    add_word(8'h7F, 1'b1);
    // everything after a zero byte is ignored
    add_word("A", 1'b0);
    add_word(8'h00, 1'b0);
    add_word("B", 1'b1);
    // high and control bytes are skipped
    add_word(8'hFF, 1'b0);
    add_word(8'h80, 1'b0);
    add_word(8'h01, 1'b0);
    add_word("z", 1'b1);
    // random messages, mostly mappable characters
    while (char_words.size() < WORD_COUNT) begin
      msg_len = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      for (int k = 0; k < msg_len; k++) begin
        pick = $urandom_range(99);
        if (pick < 15) b = CHAR_W'($urandom_range(47, 38));
        else if (pick < 30) b = CHAR_W'($urandom_range(57, 48));
        else if (pick < 55) b = CHAR_W'($urandom_range(90, 65));
        else if (pick < 75) b = CHAR_W'($urandom_range(122, 97));
        else if (pick < 78) b = 8'h00;
        else b = CHAR_W'($urandom_range(255));
        add_word(b, k == msg_len - 1);
      end
    end
    wait (!rst);
    while (char_words.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (frame_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // reset
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // watchdog
  initial begin
    #3000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
